@@ hw/rtl/smpd_pkg.sv @@
// Shared types, constants and helpers for the serial mouse packet device.
// Used by smpd_motion, smpd_byte_fifo and serial_mouse_packet_device.
// No dependencies.
package smpd_pkg;

   // Byte queue geometry
   localparam int QUEUE_DEPTH = 16;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   // Bytes in one motion packet
   localparam int PACKET_BYTES = 3;

   // Operation codes
   localparam logic [1:0] OP_MOTION = 2'd0;
   localparam logic [1:0] OP_MODEM  = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;

   // Identification byte sent on power-up ('M')
   localparam logic [6:0] SYNC_BYTE = 7'h4D;

   // Q16.8 accumulator limits
   localparam logic signed [23:0] ACC_MAX = 24'sh7FFFFF;
   localparam logic signed [23:0] ACC_MIN = -24'sh800000;

   // Whole-mickey clamp limits
   localparam logic signed [15:0] WHOLE_MAX = 16'sh007F;
   localparam logic signed [15:0] WHOLE_MIN = -16'sh0080;

   typedef struct packed {
      logic [1:0]         operation;
      logic [2:0]         button_bits;
      logic signed [15:0] delta_x;
      logic signed [15:0] delta_y;
      logic [3:0]         modem_lines;
   } req_type;

   typedef struct packed {
      logic [7:0] read_byte;
      logic       read_valid;
      logic       has_data;
      logic       clear_to_send;
      logic       data_set_ready;
   } rsp_type;

   typedef struct packed {
      logic signed [23:0] accum_x;
      logic signed [23:0] accum_y;
      logic [2:0]         last_buttons;
      logic               buttons_changed;
      logic               power_on;
      logic               motion_enable;
   } mouse_state_type;

   typedef logic [PACKET_BYTES-1:0][6:0] packet_type;

   typedef struct packed {
      logic signed [23:0] accum_x;
      logic signed [23:0] accum_y;
      logic               buttons_changed;
      logic               send;
      packet_type         packet;
   } motion_result_type;

   typedef struct packed {
      logic       pop;
      logic       push_packet;
      logic       restart;
      packet_type packet;
   } fifo_cmd_type;

   typedef struct packed {
      logic [6:0] head_byte;
      logic       not_empty;
      logic       has_room;
      logic       not_empty_next;
   } fifo_status_type;

   // Pointer advance with wrap at the queue depth (step below the depth)
   function automatic logic [QUEUE_AW-1:0] queue_wrap_add(input logic [QUEUE_AW-1:0] ptr,
                                                          input logic [1:0] step);
      logic [QUEUE_AW:0] sum;
      sum = {1'b0, ptr} + (QUEUE_AW + 1)'(step);
      if (sum >= (QUEUE_AW + 1)'(QUEUE_DEPTH)) begin
         sum = sum - (QUEUE_AW + 1)'(QUEUE_DEPTH);
      end
      return sum[QUEUE_AW-1:0];
   endfunction

endpackage

@@ hw/rtl/smpd_motion.sv @@
// Motion report datapath: saturating accumulate, whole-mickey extraction,
// packet build and send decision. Depends on smpd_pkg.
module smpd_motion
   import smpd_pkg::*;
(
   input  req_type           item,
   input  mouse_state_type   state,
   input  logic              queue_has_room,
   output motion_result_type result
);

   // Saturating add of a Q8.8 delta into a Q16.8 accumulator
   function automatic logic signed [23:0] sat_add(input logic signed [23:0] acc,
                                                  input logic signed [15:0] delta);
      logic signed [24:0] sum;
      sum = 25'(acc) + 25'(delta);
      if (!sum[24] && sum[23]) begin
         return ACC_MAX;
      end else if (sum[24] && !sum[23]) begin
         return ACC_MIN;
      end
      return sum[23:0];
   endfunction

   // Integer part, truncated toward zero
   function automatic logic signed [15:0] whole_part(input logic signed [23:0] acc);
      logic round_up;
      round_up = acc[23] && (acc[7:0] != 8'h00);
      return acc[23:8] + 16'(round_up);
   endfunction

   function automatic logic signed [7:0] clamp8(input logic signed [15:0] v);
      if (v > WHOLE_MAX) begin
         return 8'sh7F;
      end else if (v < WHOLE_MIN) begin
         return -8'sh80;
      end
      return v[7:0];
   endfunction

   logic signed [23:0] sat_x, sat_y;
   logic signed [15:0] whole_x, whole_y;
   logic signed [7:0]  clamp_x, clamp_y;
   logic [7:0]         x_byte, y_byte;
   logic               changed;
   logic               moved;

   // Accumulate and extract whole mickeys
   always_comb begin
      sat_x   = sat_add(state.accum_x, item.delta_x);
      sat_y   = sat_add(state.accum_y, item.delta_y);
      whole_x = whole_part(sat_x);
      whole_y = whole_part(sat_y);
      clamp_x = clamp8(whole_x);
      clamp_y = clamp8(whole_y);
      changed = state.buttons_changed || (item.button_bits != state.last_buttons);
      moved   = (whole_x != 16'sd0) || (whole_y != 16'sd0);
   end

   // Send decision, accumulator update and packet bytes
   always_comb begin
      result.send = state.power_on && ((moved && state.motion_enable) || changed)
                    && queue_has_room;
      x_byte = state.motion_enable ? clamp_x : 8'h00;
      y_byte = state.motion_enable ? clamp_y : 8'h00;
      if (result.send) begin
         // sent amount is sign extended to the accumulator width
         result.accum_x         = sat_x - {{8{clamp_x[7]}}, clamp_x, 8'h00};
         result.accum_y         = sat_y - {{8{clamp_y[7]}}, clamp_y, 8'h00};
         result.buttons_changed = 1'b0;
      end else begin
         result.accum_x         = sat_x;
         result.accum_y         = sat_y;
         result.buttons_changed = changed;
      end
      // left and right swap places in the header byte
      result.packet[0] = {1'b1, item.button_bits[0], item.button_bits[1],
                          y_byte[7:6], x_byte[7:6]};
      result.packet[1] = {1'b0, x_byte[5:0]};
      result.packet[2] = {1'b0, y_byte[5:0]};
   end

endmodule

@@ hw/rtl/smpd_byte_fifo.sv @@
// Register-based byte queue: one pop, a three-byte packet push, or a
// restart that empties it and stores the sync byte. Depends on smpd_pkg.
module smpd_byte_fifo
   import smpd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  fifo_cmd_type    cmd,
   output fifo_status_type status
);

   logic [6:0]          mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] head_ff, head_in;
   logic [QUEUE_AW-1:0] tail_ff, tail_in;
   logic [QUEUE_CW-1:0] count_ff, count_in;
   logic [QUEUE_AW-1:0] tail_p1, tail_p2;

   assign tail_p1 = queue_wrap_add(tail_ff, 2'd1);
   assign tail_p2 = queue_wrap_add(tail_ff, 2'd2);

   // Pointer and count update
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      priority if (cmd.restart) begin
         head_in  = '0;
         tail_in  = queue_wrap_add('0, 2'd1);
         count_in = QUEUE_CW'(1);
      end else if (cmd.push_packet) begin
         tail_in  = queue_wrap_add(tail_ff, 2'(PACKET_BYTES));
         count_in = count_ff + QUEUE_CW'(PACKET_BYTES);
      end else if (cmd.pop && (count_ff != '0)) begin
         head_in  = queue_wrap_add(head_ff, 2'd1);
         count_in = count_ff - QUEUE_CW'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Storage writes
   always_ff @(posedge clock) begin
      if (cmd.restart) begin
         mem_ff['0] <= SYNC_BYTE;
      end else if (cmd.push_packet) begin
         mem_ff[tail_ff] <= cmd.packet[0];
         mem_ff[tail_p1] <= cmd.packet[1];
         mem_ff[tail_p2] <= cmd.packet[2];
      end
   end

   assign status.head_byte      = mem_ff[head_ff];
   assign status.not_empty      = (count_ff != '0);
   assign status.has_room       = (count_ff <= QUEUE_CW'(QUEUE_DEPTH - PACKET_BYTES));
   assign status.not_empty_next = (count_in != '0);

endmodule

@@ hw/rtl/serial_mouse_packet_device.sv @@
// Serial mouse packet device, top level: input register, per-item state
// update, byte queue and result register. Depends on smpd_pkg, smpd_motion
// and smpd_byte_fifo.
//
//   channel | ports                          | carries
//   --------+--------------------------------+--------------------------------
//   request | req_valid, req_ready, req_data | one operation (req_type)
//   result  | rsp_valid, rsp_ready, rsp_data | one status/read result (rsp_type)
//
// One item per cycle sustained while the result is not stalled. An item
// transfers into the input register, is processed there once the result
// register is free or its result transfers, and then lands in the result
// register, from which its result is offered on the result channel.
// Synchronous reset clears the mouse state, queue pointers and both valids.
// A stalled result holds the result register; the input register still
// drains into it in the cycle the result transfers.
module serial_mouse_packet_device
   import smpd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic              in_valid_ff;
   req_type           in_item_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_item_ff, rsp_item_in;
   mouse_state_type   state_ff, state_in;
   motion_result_type motion;
   fifo_cmd_type      fifo_cmd;
   fifo_status_type   fifo_status;
   logic              advance;

   // Pipeline flow control
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   smpd_motion u_motion (
      .item           (in_item_ff),
      .state          (state_ff),
      .queue_has_room (fifo_status.has_room),
      .result         (motion)
   );

   smpd_byte_fifo u_fifo (
      .clock  (clock),
      .reset  (reset),
      .cmd    (fifo_cmd),
      .status (fifo_status)
   );

   // Per-operation state update and queue commands
   always_comb begin
      state_in            = state_ff;
      fifo_cmd.pop        = 1'b0;
      fifo_cmd.push_packet = 1'b0;
      fifo_cmd.restart    = 1'b0;
      fifo_cmd.packet     = motion.packet;
      rsp_item_in.read_byte  = 8'h00;
      rsp_item_in.read_valid = 1'b0;
      if (advance) begin
         unique case (in_item_ff.operation)
            OP_MOTION: begin
               state_in.accum_x         = motion.accum_x;
               state_in.accum_y         = motion.accum_y;
               state_in.last_buttons    = in_item_ff.button_bits;
               state_in.buttons_changed = motion.buttons_changed;
               fifo_cmd.push_packet     = motion.send;
            end
            OP_MODEM: begin
               state_in.power_on      = in_item_ff.modem_lines[1];
               state_in.motion_enable = in_item_ff.modem_lines[0];
               fifo_cmd.restart       = in_item_ff.modem_lines[1] && !state_ff.power_on;
            end
            OP_READ: begin
               // an empty queue reads as zero
               fifo_cmd.pop           = fifo_status.not_empty;
               rsp_item_in.read_byte  = fifo_status.not_empty ?
                                        {1'b0, fifo_status.head_byte} : 8'h00;
               rsp_item_in.read_valid = fifo_status.not_empty;
            end
            default: begin
               state_in = state_ff;
            end
         endcase
      end
      rsp_item_in.has_data       = fifo_status.not_empty_next;
      rsp_item_in.clear_to_send  = state_in.power_on;
      rsp_item_in.data_set_ready = state_in.motion_enable;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         state_ff <= state_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_data;
      end
      if (advance) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_item_ff;

endmodule
